>>> design/phfe_pkg.sv
// shared types and constants for the packet header field extractor
package phfe_pkg;

  // field widths fixed by the interface
  localparam int BYTE_W       = 8;
  localparam int ADDR_W       = 48;
  localparam int ADDR_BYTES   = 6;
  localparam int IP_BYTES     = 4;
  localparam int TYPE_BYTES   = 2;
  localparam int QOS_W        = 6;
  localparam int STATUS_W     = 2;
  localparam int MIN_LEN_W    = 14;
  localparam int CFG_INDEX_W  = 2;
  localparam int OUT_DATA_W   = 2 * ADDR_W + QOS_W + STATUS_W;

  // default counter width
  localparam int COUNT_WIDTH_DEFAULT = 14;

  // reset values of the registers
  localparam logic [MIN_LEN_W-1:0] ETH_MIN_RESET  = MIN_LEN_W'(60);
  localparam logic [MIN_LEN_W-1:0] IPV4_MIN_RESET = MIN_LEN_W'(20);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PARSE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ETH_MIN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IPV4_MIN   = 2'd2;

  // parse modes
  localparam logic MODE_ETHERNET = 1'b0;
  localparam logic MODE_IPV4     = 1'b1;

  // tag types and header constants
  localparam logic [15:0] TYPE_VLAN     = 16'h8100;
  localparam logic [15:0] TYPE_QINQ     = 16'h88A8;
  localparam logic [15:0] TYPE_QINQ_OLD = 16'h9100;
  localparam logic [2:0]  PCP_MASK      = 3'h7;
  localparam logic [7:0]  VERSION_MASK  = 8'hf0;
  localparam logic [3:0]  IPV4_VERSION  = 4'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_SHORT       = 2'd1,
    STATUS_BAD_VERSION = 2'd2
  } status_t;

  // control fanned out to every byte cell of a chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // end-of-packet summary handed to the result stage
  typedef struct packed {
    logic mode;
    logic eth_short;
    logic ip_short;
  } finish_t;

endpackage

>>> design/packet_header_field_extractor_core.sv
// top level of the packet header field extractor
//
// channel   dir  words                          fields (low bit up)
// s_axis    in   one packet byte per word       tdata: data_byte; tlast: last_byte
// m_axis    out  one result per packet          tdata: source_address, destination_address,
//                                               qos_value, status
// cfg       in   register write, no read-back   cfg_index selects, cfg_data holds value
//
// one byte is taken every cycle while s_tready is high; captures shift through
// chains of byte cells; after the last byte the captures and the length check settle
// into registers, then the result is formed into the output register
// rst is synchronous; it clears the byte counter, the registers and the valid flags
// with the output stalled and a finished packet waiting, the input stalls as well
module packet_header_field_extractor_core #(
  parameter int COUNT_WIDTH = phfe_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // input byte stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] data_byte
  input  logic                             s_tlast,   // last_byte
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [47:0] source_address, [95:48] destination_address,
  // [101:96] qos_value, [103:102] status
  output logic [phfe_pkg::OUT_DATA_W-1:0]  m_tdata,
  // configuration
  input  logic                             cfg_we,
  input  logic [phfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [phfe_pkg::MIN_LEN_W-1:0]   cfg_data
);
  import phfe_pkg::*;

  // length needs one bit beyond the wider of counter and threshold
  localparam int LEN_W = ((COUNT_WIDTH > MIN_LEN_W) ? COUNT_WIDTH : MIN_LEN_W) + 1;

  // configuration registers
  logic                  parse_mode;
  logic [MIN_LEN_W-1:0]  eth_min;
  logic [MIN_LEN_W-1:0]  ipv4_min;

  // byte position of the next word
  logic [COUNT_WIDTH-1:0] byte_index;
  logic [COUNT_WIDTH-1:0] byte_index_next;

  logic                   accept;
  logic                   is_eth;
  logic                   is_ip;
  logic                   clear;
  logic [LEN_W-1:0]       length;

  // chain control
  cell_ctl_t              dest_ctl;
  cell_ctl_t              src_ctl;
  cell_ctl_t              type_ctl;
  logic                   ip_trunc;

  logic [7:0]             dest_q [ADDR_BYTES];
  logic [7:0]             src_q  [ADDR_BYTES];
  logic [7:0]             type_q [TYPE_BYTES];
  logic [ADDR_W-1:0]      dest_word;
  logic [ADDR_W-1:0]      source_word;
  logic [15:0]            type_word;

  // single-field captures
  logic [2:0]             pcp_outer;
  logic [2:0]             pcp_inner;
  logic [3:0]             version;
  logic [QOS_W-1:0]       dscp;

  // finished packet waiting for the result stage
  logic                   fin_valid;
  finish_t                fin;
  logic                   take;

  // a finished packet holds the captures until the result stage takes it
  assign s_tready = !fin_valid || take;
  assign accept   = s_tvalid && s_tready;

  assign is_eth   = (parse_mode == MODE_ETHERNET);
  assign is_ip    = (parse_mode == MODE_IPV4);
  assign clear    = accept && (byte_index == '0);
  assign length   = LEN_W'(byte_index) + LEN_W'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= MODE_ETHERNET;
      eth_min    <= ETH_MIN_RESET;
      ipv4_min   <= IPV4_MIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PARSE_MODE: parse_mode <= cfg_data[0];
        CFG_ETH_MIN:    eth_min    <= cfg_data;
        CFG_IPV4_MIN:   ipv4_min   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // saturating byte counter, back to zero after the last byte
  always_comb begin
    byte_index_next = byte_index;
    if (accept) begin
      if (s_tlast) begin
        byte_index_next = '0;
      end else if (byte_index != '1) begin
        byte_index_next = byte_index + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  // shift windows: ethernet macs and type, ipv4 addresses
  always_comb begin
    dest_ctl.clear = clear;
    src_ctl.clear  = clear;
    type_ctl.clear = clear;
    dest_ctl.shift = accept && (is_eth ? (byte_index <= COUNT_WIDTH'(5))
                                       : (byte_index >= COUNT_WIDTH'(16) &&
                                          byte_index <= COUNT_WIDTH'(19)));
    src_ctl.shift  = accept && (is_eth ? (byte_index >= COUNT_WIDTH'(6) &&
                                          byte_index <= COUNT_WIDTH'(11))
                                       : (byte_index >= COUNT_WIDTH'(12) &&
                                          byte_index <= COUNT_WIDTH'(15)));
    type_ctl.shift = accept && is_eth && (byte_index >= COUNT_WIDTH'(12) &&
                                          byte_index <= COUNT_WIDTH'(13));
  end

  // ipv4 addresses keep only their low four bytes
  assign ip_trunc = is_ip;

  // address chains, cell zero takes the incoming byte
  for (genvar i = 0; i < ADDR_BYTES; i++) begin : g_addr
    logic [7:0] dest_din;
    logic [7:0] src_din;
    logic       keep;

    if (i == 0) begin : g_head
      assign dest_din = s_tdata;
      assign src_din  = s_tdata;
      assign keep     = 1'b1;
    end else begin : g_body
      assign dest_din = dest_q[i-1];
      assign src_din  = src_q[i-1];
      assign keep     = !clear && !(ip_trunc && (i >= IP_BYTES));
    end

    phfe_byte_cell u_dest_cell (
      .clk  (clk),
      .ctl  (dest_ctl),
      .keep (keep),
      .din  (dest_din),
      .q    (dest_q[i])
    );

    phfe_byte_cell u_src_cell (
      .clk  (clk),
      .ctl  (src_ctl),
      .keep (keep),
      .din  (src_din),
      .q    (src_q[i])
    );

    assign dest_word[BYTE_W*i +: BYTE_W]   = dest_q[i];
    assign source_word[BYTE_W*i +: BYTE_W] = src_q[i];
  end

  // ethertype chain
  for (genvar i = 0; i < TYPE_BYTES; i++) begin : g_type
    logic [7:0] type_din;
    logic       keep;

    if (i == 0) begin : g_head
      assign type_din = s_tdata;
      assign keep     = 1'b1;
    end else begin : g_body
      assign type_din = type_q[i-1];
      assign keep     = !clear;
    end

    phfe_byte_cell u_type_cell (
      .clk  (clk),
      .ctl  (type_ctl),
      .keep (keep),
      .din  (type_din),
      .q    (type_q[i])
    );

    assign type_word[BYTE_W*i +: BYTE_W] = type_q[i];
  end

  // pcp of the first and second tag, version and dscp
  always_ff @(posedge clk) begin
    if (accept && is_eth && byte_index == COUNT_WIDTH'(14)) begin
      pcp_outer <= s_tdata[7:5] & PCP_MASK;
    end else if (clear) begin
      pcp_outer <= '0;
    end
    if (accept && is_eth && byte_index == COUNT_WIDTH'(16)) begin
      pcp_inner <= s_tdata[7:5] & PCP_MASK;
    end else if (clear) begin
      pcp_inner <= '0;
    end
    if (accept && is_ip && byte_index == '0) begin
      version <= 4'((s_tdata & VERSION_MASK) >> 4);
    end else if (clear) begin
      version <= '0;
    end
    if (accept && is_ip && byte_index == COUNT_WIDTH'(1)) begin
      dscp <= s_tdata[7:2];
    end else if (clear) begin
      dscp <= '0;
    end
  end

  // end of packet: mode and length checks as of the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (accept && s_tlast) begin
      fin_valid <= 1'b1;
    end else if (take) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      fin.mode      <= parse_mode;
      fin.eth_short <= length < LEN_W'(eth_min);
      fin.ip_short  <= length < LEN_W'(ipv4_min);
    end
  end

  phfe_result u_result (
    .clk         (clk),
    .rst         (rst),
    .fin_valid   (fin_valid),
    .fin         (fin),
    .dest_word   (dest_word),
    .source_word (source_word),
    .type_word   (type_word),
    .pcp_outer   (pcp_outer),
    .pcp_inner   (pcp_inner),
    .version     (version),
    .dscp        (dscp),
    .take        (take),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

>>> design/phfe_byte_cell.sv
// one byte cell of a capture shift chain
module phfe_byte_cell (
  input  logic                  clk,
  input  phfe_pkg::cell_ctl_t   ctl,
  input  logic                  keep,
  input  logic [7:0]            din,
  output logic [7:0]            q
);
  import phfe_pkg::*;

  // shift takes the neighbor byte or zero, clear alone empties the cell
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= keep ? din : '0;
    end else if (ctl.clear) begin
      q <= '0;
    end
  end

endmodule

>>> design/phfe_result.sv
// result formation and output register
module phfe_result (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fin_valid,
  input  phfe_pkg::finish_t               fin,
  input  logic [phfe_pkg::ADDR_W-1:0]     dest_word,
  input  logic [phfe_pkg::ADDR_W-1:0]     source_word,
  input  logic [15:0]                     type_word,
  input  logic [2:0]                      pcp_outer,
  input  logic [2:0]                      pcp_inner,
  input  logic [3:0]                      version,
  input  logic [phfe_pkg::QOS_W-1:0]      dscp,
  output logic                            take,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [phfe_pkg::OUT_DATA_W-1:0] m_tdata
);
  import phfe_pkg::*;

  status_t            status;
  logic [QOS_W-1:0]   qos;
  logic [ADDR_W-1:0]  src;
  logic [ADDR_W-1:0]  dst;

  assign take = !m_tvalid || m_tready;

  always_comb begin
    status = STATUS_OK;
    qos    = '0;
    src    = '0;
    dst    = '0;
    if (fin.mode == MODE_ETHERNET) begin
      if (fin.eth_short) begin
        status = STATUS_SHORT;
      end else begin
        src = source_word;
        dst = dest_word;
        if (type_word == TYPE_VLAN) begin
          qos = QOS_W'(pcp_outer & PCP_MASK);
        end else if (type_word == TYPE_QINQ || type_word == TYPE_QINQ_OLD) begin
          qos = QOS_W'(pcp_inner & PCP_MASK);
        end
      end
    end else begin
      if (version != IPV4_VERSION) begin
        status = STATUS_BAD_VERSION;
      end else if (fin.ip_short) begin
        status = STATUS_SHORT;
      end else begin
        src = {{(ADDR_W-32){1'b0}}, source_word[31:0]};
        dst = {{(ADDR_W-32){1'b0}}, dest_word[31:0]};
        qos = dscp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fin_valid) begin
      m_tdata <= {status, qos, dst, src};
    end
  end

endmodule
